// ===== rtl/tskf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tskf_pkg
// Shared widths, constants, command struct and helpers for the two-axis
// scalar Kalman filter.
// ---------------------------------------------------------------------------
package tskf_pkg;

    localparam int DATA_WIDTH  = 32;   // estimate / variance width
    localparam int FRAC_BITS   = 16;   // fraction bits of all fixed-point values
    localparam int MEAS_WIDTH  = 32;   // measurement and result port width
    localparam int CFG_WIDTH   = 32;   // q and r register width

    localparam int WIDE_WIDTH  = (DATA_WIDTH > MEAS_WIDTH) ? DATA_WIDTH : MEAS_WIDTH;
    localparam int SUM_WIDTH   = WIDE_WIDTH + 1;
    localparam int GAIN_WIDTH  = FRAC_BITS + 1;
    localparam int MUL_A_WIDTH = DATA_WIDTH + 1;
    localparam int PROD_WIDTH  = MUL_A_WIDTH + GAIN_WIDTH;
    localparam int SCL_WIDTH   = PROD_WIDTH - FRAC_BITS;
    localparam int EXT_WIDTH   = DATA_WIDTH + 3;
    localparam int CNT_WIDTH   = $clog2(FRAC_BITS);

    localparam int CFG_ADDR_WIDTH = 3;

    localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [DATA_WIDTH-1:0] VAR_ONE  = DATA_WIDTH'(64'd1 << FRAC_BITS);
    localparam logic [DATA_WIDTH-1:0] VAR_MAX  = {DATA_WIDTH{1'b1}};
    localparam logic signed [DATA_WIDTH-1:0] EST_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] EST_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    localparam logic [CFG_WIDTH-1:0] Q_RESET = CFG_WIDTH'(655);
    localparam logic [CFG_WIDTH-1:0] R_RESET = CFG_WIDTH'(6554);

    // input transaction kinds
    localparam logic KIND_MEASURE = 1'b0;
    localparam logic KIND_RESET   = 1'b1;

    typedef enum logic {
        REG_PROCESS_NOISE = 1'b0,
        REG_MEASURE_NOISE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic load;      // capture measurement
        logic clear;     // restore filter state
        logic pred;      // variance predict, innovation
        logic div_init;  // set up gain division
        logic div_step;  // one restoring division step
        logic mul_est;   // product = |innovation| * k
        logic mul_var;   // estimate update, product = p * (1 - k)
        logic upd_var;   // variance update
        logic load_out;  // copy estimate into result register
    } cmd_t;

    // sign-extend a measurement and clamp it to the estimate range
    function automatic logic signed [DATA_WIDTH-1:0] sat_meas(
        input logic signed [MEAS_WIDTH-1:0] m
    );
        logic signed [WIDE_WIDTH-1:0] w;
        logic signed [WIDE_WIDTH-1:0] hi;
        logic signed [WIDE_WIDTH-1:0] lo;
        w  = WIDE_WIDTH'(m);
        hi = WIDE_WIDTH'(EST_MAX);
        lo = WIDE_WIDTH'(EST_MIN);
        if (w > hi)
            return EST_MAX;
        else if (w < lo)
            return EST_MIN;
        else
            return DATA_WIDTH'(w);
    endfunction

endpackage

// ===== rtl/tskf_axis.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tskf_axis
// Datapath of one filter axis: predict, iterative gain divider, shared
// multiplier, saturating estimate and variance updates, result register.
// ---------------------------------------------------------------------------
module tskf_axis (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tskf_pkg::cmd_t                         cmd,
    input  logic [tskf_pkg::CFG_WIDTH-1:0]         q,
    input  logic [tskf_pkg::CFG_WIDTH-1:0]         r,
    input  logic signed [tskf_pkg::MEAS_WIDTH-1:0] meas,
    output logic signed [tskf_pkg::MEAS_WIDTH-1:0] est_out
);
    import tskf_pkg::*;

    logic signed [DATA_WIDTH-1:0] est_reg, est_next;
    logic [DATA_WIDTH-1:0]        var_reg, var_next;

    logic signed [DATA_WIDTH-1:0] z_reg;
    logic [DATA_WIDTH-1:0]        p_reg;
    logic [SUM_WIDTH-1:0]         d_reg;
    logic [SUM_WIDTH:0]           rem_reg;
    logic [GAIN_WIDTH-1:0]        k_reg;
    logic                         fix_reg;
    logic [MUL_A_WIDTH-1:0]       mag_reg;
    logic                         neg_reg;
    logic [PROD_WIDTH-1:0]        prod_reg;
    logic signed [MEAS_WIDTH-1:0] out_reg;

    logic [SUM_WIDTH-1:0]         p_sum;
    logic [DATA_WIDTH-1:0]        p_sat;
    logic signed [DATA_WIDTH:0]   innov;
    logic [MUL_A_WIDTH-1:0]       mag;
    logic [SUM_WIDTH-1:0]         d_sum;
    logic [SUM_WIDTH:0]           rem_sh;
    logic                         ge;
    logic [SUM_WIDTH:0]           rem_new;
    logic [MUL_A_WIDTH-1:0]       mul_a;
    logic [GAIN_WIDTH-1:0]        mul_b;
    logic [PROD_WIDTH-1:0]        prod;
    logic [SCL_WIDTH-1:0]         scaled;
    logic signed [EXT_WIDTH-1:0]  est_ext;
    logic signed [EXT_WIDTH-1:0]  step_ext;
    logic signed [EXT_WIDTH-1:0]  est_sum;
    logic signed [DATA_WIDTH-1:0] est_sat;
    logic [DATA_WIDTH-1:0]        var_sat;

    // predict and innovation
    always_comb
    begin
        p_sum = SUM_WIDTH'(var_reg) + SUM_WIDTH'(q);
        p_sat = (p_sum > SUM_WIDTH'(VAR_MAX)) ? VAR_MAX : p_sum[DATA_WIDTH-1:0];
        innov = (DATA_WIDTH+1)'(z_reg) - (DATA_WIDTH+1)'(est_reg);
        mag   = innov[DATA_WIDTH] ? MUL_A_WIDTH'(-innov) : MUL_A_WIDTH'(innov);
    end

    // gain divider
    always_comb
    begin
        d_sum   = SUM_WIDTH'(p_reg) + SUM_WIDTH'(r);
        rem_sh  = {rem_reg[SUM_WIDTH-1:0], 1'b0};
        ge      = (rem_sh >= {1'b0, d_reg});
        rem_new = ge ? (rem_sh - {1'b0, d_reg}) : rem_sh;
    end

    // shared multiplier and the two updates that follow it
    always_comb
    begin
        mul_a    = cmd.mul_var ? {1'b0, p_reg} : mag_reg;
        mul_b    = cmd.mul_var ? (GAIN_ONE - k_reg) : k_reg;
        prod     = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
        scaled   = prod_reg[PROD_WIDTH-1:FRAC_BITS];
        est_ext  = EXT_WIDTH'(est_reg);
        step_ext = $signed({1'b0, scaled});
        est_sum  = neg_reg ? (est_ext - step_ext) : (est_ext + step_ext);
        if (est_sum > EXT_WIDTH'(EST_MAX))
            est_sat = EST_MAX;
        else if (est_sum < EXT_WIDTH'(EST_MIN))
            est_sat = EST_MIN;
        else
            est_sat = DATA_WIDTH'(est_sum);
        var_sat = (|scaled[SCL_WIDTH-1:DATA_WIDTH]) ? VAR_MAX : scaled[DATA_WIDTH-1:0];
    end

    always_comb
    begin
        est_next = est_reg;
        var_next = var_reg;
        if (cmd.clear)
        begin
            est_next = '0;
            var_next = VAR_ONE;
        end
        else
        begin
            if (cmd.mul_var)
                est_next = est_sat;
            if (cmd.upd_var)
                var_next = var_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg <= '0;
            var_reg <= VAR_ONE;
        end
        else
        begin
            est_reg <= est_next;
            var_reg <= var_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            z_reg <= sat_meas(meas);
        if (cmd.pred)
        begin
            p_reg   <= p_sat;
            mag_reg <= mag;
            neg_reg <= innov[DATA_WIDTH];
        end
        if (cmd.div_init)
        begin
            d_reg   <= d_sum;
            rem_reg <= {1'b0, SUM_WIDTH'(p_reg)};
            // both zero gives zero gain; zero r gives unit gain
            if (d_sum == '0)
            begin
                k_reg   <= '0;
                fix_reg <= 1'b1;
            end
            else if (SUM_WIDTH'(p_reg) >= d_sum)
            begin
                k_reg   <= GAIN_ONE;
                fix_reg <= 1'b1;
            end
            else
            begin
                k_reg   <= '0;
                fix_reg <= 1'b0;
            end
        end
        if (cmd.div_step && !fix_reg)
        begin
            rem_reg <= rem_new;
            k_reg   <= {k_reg[GAIN_WIDTH-2:0], ge};
        end
        if (cmd.mul_est || cmd.mul_var)
            prod_reg <= prod;
        if (cmd.load_out)
            out_reg <= MEAS_WIDTH'(est_reg);
    end

    assign est_out = out_reg;

endmodule

// ===== rtl/tskf_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tskf_ctrl
// Sequencer for the filter: steps both axis datapaths through predict,
// gain division, multiply and update, and owns the result valid flag.
// ---------------------------------------------------------------------------
module tskf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           kind,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output tskf_pkg::cmd_t cmd
);
    import tskf_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PRED = 8'b0000_0010,
        S_INIT = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_MULE = 8'b0001_0000,
        S_MULV = 8'b0010_0000,
        S_UPDV = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 accept;
    logic                 out_free;
    logic                 is_reset;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign is_reset = (kind == KIND_RESET);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = is_reset ? S_OUT : S_PRED;
            end
            S_PRED: state_next = S_INIT;
            S_INIT:
            begin
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + CNT_WIDTH'(1);
                if (cnt_reg == CNT_WIDTH'(FRAC_BITS - 1))
                    state_next = S_MULE;
            end
            S_MULE: state_next = S_MULV;
            S_MULV: state_next = S_UPDV;
            S_UPDV: state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.load     = accept;
        cmd.clear    = accept && is_reset;
        cmd.pred     = (state_reg == S_PRED);
        cmd.div_init = (state_reg == S_INIT);
        cmd.div_step = (state_reg == S_DIV);
        cmd.mul_est  = (state_reg == S_MULE);
        cmd.mul_var  = (state_reg == S_MULV);
        cmd.upd_var  = (state_reg == S_UPDV);
        cmd.load_out = (state_reg == S_OUT) && out_free;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/two_axis_scalar_kalman.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_axis_scalar_kalman
// Two independent scalar Kalman filters (random-walk model) smoothing x/y
// position measurements in signed Q16.16, with APB-programmed q and r.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_stall    kind, meas_x, meas_y
// output    out        out_valid/out_stall  out_x, out_y
// config    in         APB psel/penable     paddr, pwdata, prdata
//
// A measurement transaction runs predict, divider set-up, the restoring
// gain divider (one bit per cycle, both axes side by side), multiplies,
// variance update and result load; a reset goes straight to the result
// load. A new transaction is accepted while the previous result waits;
// only the final load waits on out_stall. rst_n idles the sequencer and
// restores the q and r defaults, zero estimates and unit variances.
// ---------------------------------------------------------------------------
module two_axis_scalar_kalman (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   kind,
    input  logic signed [tskf_pkg::MEAS_WIDTH-1:0] meas_x,
    input  logic signed [tskf_pkg::MEAS_WIDTH-1:0] meas_y,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [tskf_pkg::MEAS_WIDTH-1:0] out_x,
    output logic signed [tskf_pkg::MEAS_WIDTH-1:0] out_y,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [tskf_pkg::CFG_ADDR_WIDTH-1:0]    paddr,
    input  logic [tskf_pkg::CFG_WIDTH-1:0]         pwdata,
    output logic [tskf_pkg::CFG_WIDTH-1:0]         prdata,
    output logic                                   pready
);
    import tskf_pkg::*;

    logic [CFG_WIDTH-1:0] q_reg, q_next;
    logic [CFG_WIDTH-1:0] r_reg, r_next;
    logic                 cfg_write;
    reg_idx_t             reg_idx;
    cmd_t                 cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = reg_idx_t'(paddr[2]);

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        if (cfg_write)
        begin
            unique case (reg_idx)
                REG_PROCESS_NOISE: q_next = pwdata;
                REG_MEASURE_NOISE: r_next = pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PROCESS_NOISE: prdata = q_reg;
            REG_MEASURE_NOISE: prdata = r_reg;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= Q_RESET;
            r_reg <= R_RESET;
        end
        else
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    tskf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    tskf_axis u_axis_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q       (q_reg),
        .r       (r_reg),
        .meas    (meas_x),
        .est_out (out_x)
    );

    tskf_axis u_axis_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q       (q_reg),
        .r       (r_reg),
        .meas    (meas_y),
        .est_out (out_y)
    );

    // after a transaction is taken the sequencer must be busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted but sequencer not busy");

    // a new result only appears as the sequencer returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result loaded while sequencer busy");

    // datapath steps never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.pred, cmd.div_init, cmd.div_step, cmd.mul_est,
                  cmd.mul_var, cmd.upd_var, cmd.load_out}))
        else $error("overlapping datapath commands");

    // the result register is loaded only when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || !out_stall))
        else $error("result overwritten while stalled");

endmodule
